// ----- rtl/playfair_cipher_defines.svh -----
// Assertion macros used by the playfair cipher top level.
`ifndef PLAYFAIR_CIPHER_DEFINES_SVH
`define PLAYFAIR_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PFC_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("playfair_cipher: check failed");
// Next-cycle implication, checked outside reset.
`define PFC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("playfair_cipher: check failed");
`else
`define PFC_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons)
`define PFC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons)
`endif
`endif

// ----- rtl/pfc_pkg.sv -----
// Types, constants and helper functions of the playfair cipher.
package pfc_pkg;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;

  localparam letter_t LETTER_X = 5'd23;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_Z = 5'd25;
  localparam cell_t   FILL_FULL = 5'd25;
  localparam logic [2:0] KEYWORD_LAST = 3'd6;

  localparam logic [6:0] ASCII_A = 7'd65;
  localparam logic [6:0] ASCII_Z = 7'd90;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef enum logic [1:0] {
    OP_KEY_CHAR = 2'd0,
    OP_KEY_END  = 2'd1,
    OP_MSG_CHAR = 2'd2,
    OP_MSG_END  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_KEY_LETTER,
    CMD_KEY_MARK,
    CMD_KEY_END,
    CMD_MSG_LETTER,
    CMD_MSG_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    letter_t   letter;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEYWORD,
    ST_ALPHA,
    ST_POS,
    ST_CALC,
    ST_RD1,
    ST_EM1,
    ST_RD2,
    ST_EM2
  } back_state_t;

  // Letters of the default key KEYWORD
  function automatic letter_t keyword_letter(input logic [2:0] i);
    letter_t l;
    case (i)
      3'd0:    l = 5'd10;
      3'd1:    l = 5'd4;
      3'd2:    l = 5'd24;
      3'd3:    l = 5'd22;
      3'd4:    l = 5'd14;
      3'd5:    l = 5'd17;
      3'd6:    l = 5'd3;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

  // Uppercase a byte; returns {is_letter, letter index}
  function automatic logic [5:0] decode_char(input logic [7:0] code);
    logic [7:0] up;
    up = code;
    if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) up = code - CASE_OFFSET;
    if (up >= CHAR_UPPER_A && up <= CHAR_UPPER_Z) return {1'b1, 5'(up - CHAR_UPPER_A)};
    return 6'd0;
  endfunction

  // Cell 0..24 to {row, col}
  function automatic logic [5:0] split_cell(input cell_t p);
    logic [2:0] row;
    logic [4:0] base;
    row = (p >= 5'd20) ? 3'd4 : (p >= 5'd15) ? 3'd3 : (p >= 5'd10) ? 3'd2 :
          (p >= 5'd5) ? 3'd1 : 3'd0;
    base = {row, 2'b00} + {2'b00, row};
    return {row, 3'(p - base)};
  endfunction

  // {row, col} to cell 0..24
  function automatic cell_t join_cell(input logic [2:0] row, input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

  // Step a row or column forward (encrypt) or back (decrypt), wrapping at five
  function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic fwd);
    logic [3:0] s;
    s = {1'b0, v} + (fwd ? 4'd1 : 4'd4);
    if (s >= 4'd5) s = s - 4'd5;
    return s[2:0];
  endfunction

endpackage

// ----- rtl/pfc_if.sv -----
// Channel interfaces of the playfair cipher.
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_code;
  modport source (output valid, operation, char_code, input ready);
  modport sink (input valid, operation, char_code, output ready);
endinterface

interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] letter;
  logic       last;
  modport source (output valid, letter, last, input ready);
  modport sink (input valid, letter, last, output ready);
endinterface

interface pfc_cfg_if;
  logic valid;
  logic ready;
  logic encrypt_mode;
  modport source (output valid, encrypt_mode, input ready);
  modport sink (input valid, encrypt_mode, output ready);
endinterface

interface pfc_cmd_if;
  logic          valid;
  logic          ready;
  pfc_pkg::cmd_t cmd;
  modport source (output valid, cmd, input ready);
  modport sink (input valid, cmd, output ready);
endinterface

// ----- rtl/pfc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/pfc_front.sv -----
// Front end: accepts input transfers and classifies them into commands.
module pfc_front (
  pfc_in_if.sink     in_ch,
  pfc_cmd_if.source  cmd_ch
);

  logic [5:0]   dec;
  logic         keep;
  pfc_pkg::cmd_t cmd;

  assign dec = pfc_pkg::decode_char(in_ch.char_code);

  // Classify the operation; drop non-letters of the message here
  always_comb begin
    keep       = 1'b1;
    cmd.kind   = pfc_pkg::CMD_KEY_MARK;
    cmd.letter = dec[4:0];
    case (pfc_pkg::op_t'(in_ch.operation))
      pfc_pkg::OP_KEY_CHAR: begin
        if (dec[5] && dec[4:0] != pfc_pkg::LETTER_J) begin
          cmd.kind = pfc_pkg::CMD_KEY_LETTER;
        end else begin
          cmd.kind = pfc_pkg::CMD_KEY_MARK;
        end
      end
      pfc_pkg::OP_KEY_END: begin
        cmd.kind = pfc_pkg::CMD_KEY_END;
      end
      pfc_pkg::OP_MSG_CHAR: begin
        cmd.kind = pfc_pkg::CMD_MSG_LETTER;
        keep     = dec[5];
        if (dec[4:0] == pfc_pkg::LETTER_J) begin
          cmd.letter = pfc_pkg::LETTER_I;
        end
      end
      pfc_pkg::OP_MSG_END: begin
        cmd.kind = pfc_pkg::CMD_MSG_END;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_ch.valid = in_ch.valid && keep;
  assign cmd_ch.cmd   = cmd;
  assign in_ch.ready  = cmd_ch.ready;

endmodule

// ----- rtl/pfc_queue.sv -----
// Short command queue between the front and back ends.
module pfc_queue #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  pfc_cmd_if.sink   wr_ch,
  pfc_cmd_if.source rd_ch
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pfc_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign wr_ch.ready = (count_r != CW'(DEPTH));
  assign rd_ch.valid = (count_r != '0);
  assign rd_ch.cmd   = mem_r[rd_ptr_r];
  assign push        = wr_ch.valid && wr_ch.ready;
  assign pop         = rd_ch.valid && rd_ch.ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry on a write transfer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_ch.cmd;
    end
  end

endmodule

// ----- rtl/pfc_back.sv -----
// Back end: builds the key square and transforms digraphs.
module pfc_back (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      encrypt_mode,
  pfc_cmd_if.sink   cmd_ch,
  pfc_out_if.source out_ch,
  output logic      square_full
);

  pfc_pkg::back_state_t state_r, state_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [25:0]      used_r, used_nxt;
  pfc_pkg::cell_t   fill_r, fill_nxt;
  logic             raw_seen_r, raw_seen_nxt;
  pfc_pkg::letter_t pend_r, pend_nxt;
  logic             odd_r, odd_nxt;
  pfc_pkg::cell_t   held_pos_r, held_pos_nxt;
  logic             half_r, half_nxt;
  pfc_pkg::letter_t cur_r, cur_nxt;
  logic             next_valid_r, next_valid_nxt;
  pfc_pkg::letter_t next_letter_r, next_letter_nxt;
  pfc_pkg::cell_t   addr1_r, addr1_nxt;
  pfc_pkg::cell_t   addr2_r, addr2_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [6:0]       out_letter_r, out_letter_nxt;
  logic             out_last_r, out_last_nxt;

  pfc_pkg::cmd_t    cmd;
  logic             take;
  logic             need_x;
  logic             slot_free;
  logic             key_walk_last;
  logic             alpha_walk_last;
  pfc_pkg::letter_t place_letter;
  logic             place_req;
  logic             place_en;
  pfc_pkg::cell_t   pos_rdata;
  pfc_pkg::letter_t sq_rdata;
  pfc_pkg::cell_t   sq_raddr;
  logic [5:0]       rc1, rc2;
  logic             fwd;
  logic             load_out;

  assign cmd             = cmd_ch.cmd;
  assign cmd_ch.ready    = (state_r == pfc_pkg::ST_IDLE);
  assign take            = cmd_ch.valid && (state_r == pfc_pkg::ST_IDLE);
  assign square_full     = (fill_r == pfc_pkg::FILL_FULL);
  assign need_x          = encrypt_mode && odd_r && (pend_r == cmd.letter);
  assign slot_free       = !out_valid_r || out_ch.ready;
  assign key_walk_last   = (cnt_r[2:0] == pfc_pkg::KEYWORD_LAST);
  assign alpha_walk_last = (cnt_r == pfc_pkg::LETTER_Z);
  assign fwd             = encrypt_mode;

  // Pick the letter offered to the square this cycle
  always_comb begin
    place_letter = cmd.letter;
    place_req    = 1'b0;
    case (state_r)
      pfc_pkg::ST_IDLE: begin
        place_req = take && (cmd.kind == pfc_pkg::CMD_KEY_LETTER);
      end
      pfc_pkg::ST_KEYWORD: begin
        place_letter = pfc_pkg::keyword_letter(cnt_r[2:0]);
        place_req    = 1'b1;
      end
      pfc_pkg::ST_ALPHA: begin
        place_letter = cnt_r;
        place_req    = 1'b1;
      end
      default: begin
        place_req = 1'b0;
      end
    endcase
  end

  assign place_en = place_req && (place_letter != pfc_pkg::LETTER_J) && !square_full &&
                    !used_r[place_letter];

  // Square: cell to letter
  assign sq_raddr = ((state_r == pfc_pkg::ST_RD2) || (state_r == pfc_pkg::ST_EM2)) ?
                    addr2_r : addr1_r;

  pfc_ram #(.WIDTH(5), .DEPTH(25)) u_square (
    .clk     (clk),
    .wr_en   (place_en),
    .wr_addr (fill_r),
    .wr_data (place_letter),
    .rd_addr (sq_raddr),
    .rd_data (sq_rdata)
  );

  // Letter position: letter to cell
  pfc_ram #(.WIDTH(5), .DEPTH(26)) u_position (
    .clk     (clk),
    .wr_en   (place_en),
    .wr_addr (place_letter),
    .wr_data (fill_r),
    .rd_addr (cur_r),
    .rd_data (pos_rdata)
  );

  assign rc1 = pfc_pkg::split_cell(held_pos_r);
  assign rc2 = pfc_pkg::split_cell(pos_rdata);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfc_pkg::ST_IDLE: begin
        if (take) begin
          case (cmd.kind)
            pfc_pkg::CMD_KEY_END: begin
              state_nxt = raw_seen_r ? pfc_pkg::ST_ALPHA : pfc_pkg::ST_KEYWORD;
            end
            pfc_pkg::CMD_MSG_LETTER: begin
              state_nxt = square_full ? pfc_pkg::ST_POS : pfc_pkg::ST_IDLE;
            end
            pfc_pkg::CMD_MSG_END: begin
              state_nxt = (square_full && half_r) ? pfc_pkg::ST_POS : pfc_pkg::ST_IDLE;
            end
            default: begin
              state_nxt = pfc_pkg::ST_IDLE;
            end
          endcase
        end
      end
      pfc_pkg::ST_KEYWORD: begin
        if (key_walk_last) state_nxt = pfc_pkg::ST_ALPHA;
      end
      pfc_pkg::ST_ALPHA: begin
        if (alpha_walk_last) state_nxt = pfc_pkg::ST_IDLE;
      end
      pfc_pkg::ST_POS: begin
        state_nxt = pfc_pkg::ST_CALC;
      end
      pfc_pkg::ST_CALC: begin
        if (half_r) begin
          state_nxt = pfc_pkg::ST_RD1;
        end else begin
          state_nxt = next_valid_r ? pfc_pkg::ST_POS : pfc_pkg::ST_IDLE;
        end
      end
      pfc_pkg::ST_RD1: begin
        state_nxt = pfc_pkg::ST_EM1;
      end
      pfc_pkg::ST_EM1: begin
        if (slot_free) state_nxt = pfc_pkg::ST_RD2;
      end
      pfc_pkg::ST_RD2: begin
        state_nxt = pfc_pkg::ST_EM2;
      end
      pfc_pkg::ST_EM2: begin
        if (slot_free) state_nxt = next_valid_r ? pfc_pkg::ST_POS : pfc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pfc_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_nxt         = cnt_r;
    used_nxt        = used_r;
    fill_nxt        = fill_r;
    raw_seen_nxt    = raw_seen_r;
    pend_nxt        = pend_r;
    odd_nxt         = odd_r;
    held_pos_nxt    = held_pos_r;
    half_nxt        = half_r;
    cur_nxt         = cur_r;
    next_valid_nxt  = next_valid_r;
    next_letter_nxt = next_letter_r;
    addr1_nxt       = addr1_r;
    addr2_nxt       = addr2_r;
    load_out        = 1'b0;
    out_letter_nxt  = out_letter_r;
    out_last_nxt    = out_last_r;

    // Record a placed letter
    if (place_en) begin
      used_nxt[place_letter] = 1'b1;
      fill_nxt               = fill_r + 1'b1;
    end

    case (state_r)
      pfc_pkg::ST_IDLE: begin
        if (take) begin
          case (cmd.kind)
            pfc_pkg::CMD_KEY_LETTER, pfc_pkg::CMD_KEY_MARK: begin
              raw_seen_nxt = 1'b1;
            end
            pfc_pkg::CMD_KEY_END: begin
              odd_nxt  = 1'b0;
              half_nxt = 1'b0;
              cnt_nxt  = '0;
            end
            pfc_pkg::CMD_MSG_LETTER: begin
              if (square_full) begin
                // In encrypt mode pair filtered letters; an equal pair gets an X between
                if (encrypt_mode) begin
                  if (!odd_r) begin
                    pend_nxt = cmd.letter;
                    odd_nxt  = 1'b1;
                  end else begin
                    odd_nxt = 1'b0;
                  end
                end
                if (need_x) begin
                  cur_nxt         = pfc_pkg::LETTER_X;
                  next_valid_nxt  = 1'b1;
                  next_letter_nxt = cmd.letter;
                end else begin
                  cur_nxt        = cmd.letter;
                  next_valid_nxt = 1'b0;
                end
              end
            end
            pfc_pkg::CMD_MSG_END: begin
              if (square_full) begin
                odd_nxt        = 1'b0;
                cur_nxt        = pfc_pkg::LETTER_X;
                next_valid_nxt = 1'b0;
              end
            end
            default: begin
              raw_seen_nxt = raw_seen_r;
            end
          endcase
        end
      end
      pfc_pkg::ST_KEYWORD: begin
        cnt_nxt = key_walk_last ? '0 : cnt_r + 1'b1;
      end
      pfc_pkg::ST_ALPHA: begin
        cnt_nxt = alpha_walk_last ? '0 : cnt_r + 1'b1;
      end
      pfc_pkg::ST_CALC: begin
        if (!half_r) begin
          // Open a digraph
          held_pos_nxt = pos_rdata;
          half_nxt     = 1'b1;
          if (next_valid_r) begin
            cur_nxt        = next_letter_r;
            next_valid_nxt = 1'b0;
          end
        end else begin
          // Close the digraph: same row, same column or rectangle
          half_nxt = 1'b0;
          if (rc1[5:3] == rc2[5:3]) begin
            addr1_nxt = pfc_pkg::join_cell(rc1[5:3], pfc_pkg::wrap_step(rc1[2:0], fwd));
            addr2_nxt = pfc_pkg::join_cell(rc2[5:3], pfc_pkg::wrap_step(rc2[2:0], fwd));
          end else if (rc1[2:0] == rc2[2:0]) begin
            addr1_nxt = pfc_pkg::join_cell(pfc_pkg::wrap_step(rc1[5:3], fwd), rc1[2:0]);
            addr2_nxt = pfc_pkg::join_cell(pfc_pkg::wrap_step(rc2[5:3], fwd), rc2[2:0]);
          end else begin
            addr1_nxt = pfc_pkg::join_cell(rc1[5:3], rc2[2:0]);
            addr2_nxt = pfc_pkg::join_cell(rc2[5:3], rc1[2:0]);
          end
        end
      end
      pfc_pkg::ST_EM1: begin
        if (slot_free) begin
          load_out       = 1'b1;
          out_letter_nxt = pfc_pkg::ASCII_A + {2'b00, sq_rdata};
          out_last_nxt   = 1'b0;
        end
      end
      pfc_pkg::ST_EM2: begin
        if (slot_free) begin
          load_out       = 1'b1;
          out_letter_nxt = pfc_pkg::ASCII_A + {2'b00, sq_rdata};
          out_last_nxt   = 1'b1;
          if (next_valid_r) begin
            cur_nxt        = next_letter_r;
            next_valid_nxt = 1'b0;
          end
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase

    // Output slot: fill on load, drain on transfer
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfc_pkg::ST_IDLE;
      cnt_r        <= '0;
      used_r       <= '0;
      fill_r       <= '0;
      raw_seen_r   <= 1'b0;
      pend_r       <= '0;
      odd_r        <= 1'b0;
      half_r       <= 1'b0;
      next_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      used_r       <= used_nxt;
      fill_r       <= fill_nxt;
      raw_seen_r   <= raw_seen_nxt;
      pend_r       <= pend_nxt;
      odd_r        <= odd_nxt;
      half_r       <= half_nxt;
      next_valid_r <= next_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held_pos_r    <= held_pos_nxt;
    cur_r         <= cur_nxt;
    next_letter_r <= next_letter_nxt;
    addr1_r       <= addr1_nxt;
    addr2_r       <= addr2_nxt;
    out_letter_r  <= out_letter_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.letter = out_letter_r;
  assign out_ch.last   = out_last_r;

endmodule

// ----- rtl/playfair_cipher.sv -----
// Top level of the streaming playfair cipher.
//
// Channels: in_ch takes one operation per transfer (key character, end of key,
// message character, end of message) with its raw byte. out_ch gives cipher or
// plain letters in ASCII uppercase; last marks the final letter caused by one
// input transfer. cfg_ch writes encrypt_mode (1 encrypt, 0 decrypt) and is
// always ready; write it only while the block is idle.
// Timing: the front classifies in the cycle of the transfer and parks the
// command in a small queue; the back sequencer then takes a key character in
// its idle state, walks end of key one key or alphabet letter per cycle, and
// steps a message letter through position read and corner calculation; one
// that closes a digraph adds two square reads, and an inserted X adds another
// position read and calculation. The square and position memories have
// registered reads. With an empty queue out_ch.valid rises after the position
// read, corner calculation and first square read; the second letter follows
// the second square read. Reset clears the square fill state, the pairing
// and digraph state and sets encrypt mode. When out_ch stalls the held
// letter waits in the output register, the back stops and the queue absorbs
// up to QUEUE_DEPTH further input transfers before in_ch.ready drops.
`include "playfair_cipher_defines.svh"

module playfair_cipher #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  pfc_in_if.sink    in_ch,
  pfc_out_if.source out_ch,
  pfc_cfg_if.sink   cfg_ch
);

  pfc_cmd_if q_wr ();
  pfc_cmd_if q_rd ();

  logic encrypt_mode_r, encrypt_mode_nxt;
  logic back_square_full;
  logic out_letter_ok;
  logic q_msg_letter;
  logic msg_letter_ok;

  // Configuration register
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    encrypt_mode_nxt = encrypt_mode_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      encrypt_mode_nxt = cfg_ch.encrypt_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encrypt_mode_r <= 1'b1;
    end else begin
      encrypt_mode_r <= encrypt_mode_nxt;
    end
  end

  pfc_front u_front (
    .in_ch  (in_ch),
    .cmd_ch (q_wr)
  );

  pfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_ch (q_wr),
    .rd_ch (q_rd)
  );

  pfc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .encrypt_mode (encrypt_mode_r),
    .cmd_ch       (q_rd),
    .out_ch       (out_ch),
    .square_full  (back_square_full)
  );

  // Terms for the checks below
  assign out_letter_ok = (out_ch.letter >= pfc_pkg::ASCII_A) &&
                         (out_ch.letter <= pfc_pkg::ASCII_Z);
  assign q_msg_letter  = q_rd.valid && (q_rd.cmd.kind == pfc_pkg::CMD_MSG_LETTER);
  assign msg_letter_ok = (q_rd.cmd.letter != pfc_pkg::LETTER_J) &&
                         (q_rd.cmd.letter <= pfc_pkg::LETTER_Z);

  // Letters stay in the uppercase range
  `PFC_ASSERT_IMPLY(a_letter_range, clk, rst_n, out_ch.valid, out_letter_ok)
  // Results only come from a complete square
  `PFC_ASSERT_IMPLY(a_out_needs_square, clk, rst_n, out_ch.valid, back_square_full)
  // Queued message letters are real letters with J folded into I
  `PFC_ASSERT_IMPLY(a_msg_letter_clean, clk, rst_n, q_msg_letter, msg_letter_ok)
  // A complete square stays complete
  `PFC_ASSERT_NEXT(a_square_stays_full, clk, rst_n, back_square_full, back_square_full)

endmodule

// ----- tb/pfc_checker.sv -----
// Playfair cipher scoreboard: mirrors the key square and checks every output letter.
module pfc_checker
  import pfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_char_code,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [6:0] out_letter,
  input  logic       out_last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_encrypt_mode,
  output int         mismatch_count,
  output int         letters_due,
  output int         letters_checked
);

  localparam int SIDE = 5;
  localparam int CELLS = 25;
  localparam int NO_LETTER = 26;
  localparam int MAX_PER_ITEM = 4;
  localparam int REPORT_LIMIT = 20;
  localparam logic [8*7-1:0] FALLBACK_KEY = "KEYWORD";

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
  } cipher_letter_t;

  cipher_letter_t due_letters[$];
  letter_t        step_letters[$];

  // Mirror of the key square and the stream state
  letter_t     grid[CELLS];
  cell_t       home[26];
  logic [25:0] placed;
  int          filled;
  logic        key_typed;
  logic        pair_open;
  logic        half_open;
  logic        encrypting;
  letter_t     pair_first;
  letter_t     half_first;
  int          errors;
  int          checked;

  // Fold case and map A..Z to 0..25; anything else is not a letter
  function automatic int letter_of(input logic [7:0] b);
    if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) return int'(b - CHAR_LOWER_A);
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return int'(b - CHAR_UPPER_A);
    return NO_LETTER;
  endfunction

  function automatic letter_t grid_at(input int row, input int col);
    return grid[(row % SIDE) * SIDE + (col % SIDE)];
  endfunction

  // Put a letter in the next free cell unless it is J, a repeat or the square is full
  task automatic place(input int idx);
    if (idx >= NO_LETTER || idx == int'(LETTER_J) || filled >= CELLS || placed[idx]) return;
    grid[filled] = letter_t'(idx);
    home[idx] = cell_t'(filled);
    placed[idx] = 1'b1;
    filled++;
  endtask

  task automatic emit(input letter_t l);
    if (step_letters.size() < MAX_PER_ITEM) step_letters.push_back(l);
  endtask

  // Add a letter to the digraph stream; a completed digraph is transformed at once
  task automatic feed(input letter_t l);
    int r1, c1, r2, c2, s;
    if (!half_open) begin
      half_first = l;
      half_open = 1'b1;
      return;
    end
    half_open = 1'b0;
    r1 = home[half_first] / SIDE;
    c1 = home[half_first] % SIDE;
    r2 = home[l] / SIDE;
    c2 = home[l] % SIDE;
    s = encrypting ? 1 : SIDE - 1;
    if (r1 == r2) begin
      emit(grid_at(r1, c1 + s));
      emit(grid_at(r2, c2 + s));
    end else if (c1 == c2) begin
      emit(grid_at(r1 + s, c1));
      emit(grid_at(r2 + s, c2));
    end else begin
      emit(grid_at(r1, c2));
      emit(grid_at(r2, c1));
    end
  endtask

  // Work out the letters one input transfer causes and queue them
  task automatic advance_cipher(input op_t op, input logic [7:0] code);
    int i;
    int idx;
    cipher_letter_t r;
    step_letters.delete();
    case (op)
      OP_KEY_CHAR: begin
        key_typed = 1'b1;
        place(letter_of(code));
      end
      OP_KEY_END: begin
        if (!key_typed)
          for (i = 0; i < 7; i++) place(letter_of(FALLBACK_KEY[8*(6-i) +: 8]));
        for (i = 0; i < 26; i++) place(i);
        pair_open = 1'b0;
        half_open = 1'b0;
      end
      OP_MSG_CHAR: begin
        idx = letter_of(code);
        if (filled == CELLS && idx != NO_LETTER) begin
          if (idx == int'(LETTER_J)) idx = int'(LETTER_I);
          if (encrypting) begin
            if (!pair_open) begin
              pair_first = letter_t'(idx);
              pair_open = 1'b1;
            end else begin
              pair_open = 1'b0;
              if (pair_first == letter_t'(idx)) feed(LETTER_X);
            end
          end
          feed(letter_t'(idx));
        end
      end
      default: begin
        if (filled == CELLS) begin
          if (half_open) feed(LETTER_X);
          pair_open = 1'b0;
          half_open = 1'b0;
        end
      end
    endcase
    foreach (step_letters[k]) begin
      r.letter = ASCII_A + 7'(step_letters[k]);
      r.last = (k == step_letters.size() - 1);
      due_letters.push_back(r);
    end
  endtask

  // Compare each output transfer, then track configuration and input transfers
  always @(posedge clk) begin : watch
    cipher_letter_t want;
    if (!rst_n) begin
      placed = '0;
      filled = 0;
      key_typed = 1'b0;
      pair_open = 1'b0;
      half_open = 1'b0;
      pair_first = '0;
      half_first = '0;
      encrypting = 1'b1;
      due_letters.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        checked++;
        if (due_letters.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected letter: expected none, got letter %0d last %b",
                     $time, out_letter, out_last);
        end else begin
          want = due_letters.pop_front();
          if (out_letter !== want.letter || out_last !== want.last) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t: mismatch: expected letter %0d last %b, got letter %0d last %b",
                       $time, want.letter, want.last, out_letter, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) encrypting = cfg_encrypt_mode;
      if (in_valid && in_ready) advance_cipher(op_t'(in_operation), in_char_code);
    end
    mismatch_count <= errors;
    letters_due <= due_letters.size();
    letters_checked <= checked;
  end

endmodule

// ----- tb/tb_playfair_cipher.sv -----
// Top of the playfair cipher testbench: clock, reset, stimulus, stalls and verdict.
module tb_playfair_cipher;
  import pfc_pkg::*;

  localparam int ITEM_TARGET = 460;
  localparam int SETTLE_CYCLES = 120;
  localparam int KEY_EMPTY = 0;
  localparam int KEY_SYMBOLS = 1;
  localparam int KEY_MIXED = 2;

  logic clk;
  logic rst_n;

  pfc_in_if  in_ch ();
  pfc_out_if out_ch ();
  pfc_cfg_if cfg_ch ();

  int mismatch_count;
  int letters_due;
  int letters_checked;
  int items_sent;
  int msg_items;
  int mode_writes;
  int key_style;
  bit tx_steady;
  bit rx_steady;

  playfair_cipher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pfc_checker cipher_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_operation     (in_ch.operation),
    .in_char_code     (in_ch.char_code),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_letter       (out_ch.letter),
    .out_last         (out_ch.last),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_encrypt_mode (cfg_ch.encrypt_mode),
    .mismatch_count   (mismatch_count),
    .letters_due      (letters_due),
    .letters_checked  (letters_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short pauses, now and then a long one
  function automatic int random_pause();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Message or key byte: mostly letters of either case, with repeats, J and X favoured
  function automatic logic [7:0] pick_char(input logic [7:0] prev);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return prev;
    if (pick < 20) return $urandom_range(0, 1) ? "J" : "x";
    if (pick < 82)
      return 8'(($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + $urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  // Stall the result side at random
  initial begin : result_side
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 2) == 0) hold = random_pause();
      end
    end
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input op_t op, input logic [7:0] code);
    int gap;
    gap = tx_steady ? 0 : random_pause();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.char_code <= code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (op == OP_MSG_CHAR || op == OP_MSG_END) msg_items++;
  endtask

  task automatic send_text(input op_t op, input string text);
    int i;
    for (i = 0; i < text.len(); i++) send_item(op, text[i]);
  endtask

  // Drop valid, wait for every expected letter, then let the back end settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (letters_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.encrypt_mode <= mode;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    mode_writes++;
  endtask

  initial begin : stimulus
    logic [7:0] prev;
    int n, len, pick;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_KEY_CHAR;
    in_ch.char_code = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.encrypt_mode = 1'b1;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    items_sent = 0;
    msg_items = 0;
    mode_writes = 0;
    key_style = $urandom_range(0, 4);
    if (key_style > KEY_MIXED) key_style = KEY_MIXED;

    // Hold reset, then release it
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    write_mode(1'b1);
    // Message traffic before the square is complete is ignored
    send_item(OP_MSG_CHAR, "A");
    send_item(OP_MSG_END, 8'h00);

    // Key: empty (default keyword), symbols only, or mixed with a random tail
    if (key_style == KEY_SYMBOLS) begin
      send_text(OP_KEY_CHAR, "1@[\140{");
      send_item(OP_KEY_CHAR, 8'h80);
    end else if (key_style == KEY_MIXED) begin
      send_text(OP_KEY_CHAR, "pLaYjP9");
      send_item(OP_KEY_CHAR, 8'hC1);
      len = $urandom_range(0, 40);
      prev = "P";
      for (n = 0; n < len; n++) begin
        prev = pick_char(prev);
        send_item(OP_KEY_CHAR, prev);
      end
    end
    send_item(OP_KEY_END, 8'hFF);
    // A key character after the square is full changes nothing
    send_item(OP_KEY_CHAR, "Q");

    // Encrypt: equal pairs, an X pair, J folding, non-letters and an odd tail
    send_text(OP_MSG_CHAR, "AaxXJiZ");
    send_item(OP_MSG_CHAR, 8'hFF);
    send_text(OP_MSG_CHAR, "\140{b");
    send_item(OP_MSG_END, 8'h55);
    // Repeated end of key in the middle of a message drops the open pair
    send_item(OP_MSG_CHAR, "M");
    send_item(OP_KEY_END, 8'hAA);
    send_item(OP_MSG_CHAR, "N");

    // Decrypt an equal digraph, then switch back with a digraph half open
    write_mode(1'b0);
    send_text(OP_MSG_CHAR, "kkz");
    write_mode(1'b1);
    send_text(OP_MSG_CHAR, "rr");
    send_item(OP_MSG_END, 8'h00);

    // Random messages in phases, each with its own mode and pacing
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) write_mode(1'($urandom_range(0, 1)));
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      len = $urandom_range(1, 24);
      prev = "A";
      for (n = 0; n < len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          send_item(OP_KEY_CHAR, 8'($urandom_range(0, 255)));
        end else if (pick < 4) begin
          send_item(OP_KEY_END, 8'($urandom_range(0, 255)));
        end else if (pick < 5) begin
          wait_idle();
        end else begin
          prev = pick_char(prev);
          send_item(OP_MSG_CHAR, prev);
        end
      end
      if ($urandom_range(0, 4) != 0) send_item(OP_MSG_END, 8'($urandom_range(0, 255)));
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    wait_idle();
    $display("Run covered %0d input transfers (%0d message items), %0d letters, %0d mode writes.",
             items_sent, msg_items, letters_checked, mode_writes);
    $display("Key setup was %s.", key_style == KEY_EMPTY ? "empty (default keyword)" :
             key_style == KEY_SYMBOLS ? "symbols only" : "mixed letters and symbols");
    if (mismatch_count == 0 && letters_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #4000000;
    $display("Timeout with %0d letters still expected", letters_due);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
